// ===== sv/tcs_pkg.sv =====
// Shared types and constants for the tick clock event scheduler.
`default_nettype none
package tcs_pkg;

  localparam int SECS_W = 32;
  localparam int FRAC_W = 10;
  localparam int TAG_W  = 16;
  localparam int SLOT_W = 4;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_SCHED = 2'd1;
  localparam logic [OP_W-1:0] OP_SET   = 2'd2;

  typedef struct packed {
    logic [SECS_W-1:0] due_secs;
    logic [FRAC_W-1:0] due_frac;
    logic [SECS_W-1:0] rep_secs;
    logic [FRAC_W-1:0] rep_frac;
    logic [TAG_W-1:0]  tag;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_SCAN,
    ST_DRAIN,
    ST_FIND,
    ST_SETT,
    ST_PLAIN
  } state_t;

  typedef struct packed {
    logic cap;
    logic clk_adv;
    logic clk_load;
    logic scan_step;
    logic find_step;
    logic place;
    logic full;
    logic plain;
    logic drain;
  } cmd_t;

  typedef struct packed {
    logic cnt_end;
    logic slot_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== sv/tcs_ctrl.sv =====
// Sequencer for the scheduler: op decode, slot scan and free-slot search.
`default_nettype none
module tcs_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [tcs_pkg::OP_W-1:0] opcode,
  input  wire tcs_pkg::stat_t           stat,
  output tcs_pkg::cmd_t                 cmd,
  output logic                          busy
);

  tcs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tcs_pkg::ST_IDLE: begin
        if (start) begin
          case (opcode)
            tcs_pkg::OP_TICK:  state_next = tcs_pkg::ST_ADV;
            tcs_pkg::OP_SCHED: state_next = tcs_pkg::ST_FIND;
            tcs_pkg::OP_SET:   state_next = tcs_pkg::ST_SETT;
            default:           state_next = tcs_pkg::ST_PLAIN;
          endcase
        end
      end
      tcs_pkg::ST_ADV:   state_next = tcs_pkg::ST_SCAN;
      tcs_pkg::ST_SCAN: begin
        if (stat.cnt_end) state_next = tcs_pkg::ST_DRAIN;
      end
      tcs_pkg::ST_DRAIN: state_next = tcs_pkg::ST_IDLE;
      tcs_pkg::ST_FIND: begin
        if (stat.cnt_end || stat.slot_free) state_next = tcs_pkg::ST_IDLE;
      end
      tcs_pkg::ST_SETT:  state_next = tcs_pkg::ST_PLAIN;
      tcs_pkg::ST_PLAIN: state_next = tcs_pkg::ST_IDLE;
      default:           state_next = tcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      tcs_pkg::ST_IDLE: begin
        busy    = 1'b0;
        cmd.cap = start;
      end
      tcs_pkg::ST_ADV:   cmd.clk_adv = 1'b1;
      tcs_pkg::ST_SCAN:  cmd.scan_step = !stat.cnt_end;
      tcs_pkg::ST_DRAIN: cmd.drain = 1'b1;
      tcs_pkg::ST_FIND: begin
        cmd.full      = stat.cnt_end;
        cmd.place     = !stat.cnt_end && stat.slot_free;
        cmd.find_step = !stat.cnt_end && !stat.slot_free;
      end
      tcs_pkg::ST_SETT:  cmd.clk_load = 1'b1;
      tcs_pkg::ST_PLAIN: cmd.plain = 1'b1;
      default:           busy = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/tcs_dp.sv =====
// Scheduler datapath: wall clock, slot table memory, scan stage, result register.
`default_nettype none
module tcs_dp #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tcs_pkg::cmd_t              cmd,
  output tcs_pkg::stat_t                  stat,
  input  wire logic                       cfg_we,
  input  wire logic [tcs_pkg::FRAC_W-1:0] cfg_wdata,
  input  wire logic [tcs_pkg::SECS_W-1:0] time_secs,
  input  wire logic [tcs_pkg::FRAC_W-1:0] time_frac,
  input  wire logic [tcs_pkg::SECS_W-1:0] period_secs,
  input  wire logic [tcs_pkg::FRAC_W-1:0] repeat_frac,
  input  wire logic [tcs_pkg::TAG_W-1:0]  event_tag,
  output logic                            done,
  output logic                            fired,
  output logic [tcs_pkg::SLOT_W-1:0]      slot_index,
  output logic [tcs_pkg::TAG_W-1:0]       tag_out,
  output logic                            accepted,
  output logic [tcs_pkg::SECS_W-1:0]      now_secs,
  output logic [tcs_pkg::FRAC_W-1:0]      now_frac,
  output logic                            last
);

  localparam int IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNTW = $clog2(NUM_SLOTS + 1);
  localparam int XW   = (IDXW > tcs_pkg::SLOT_W) ? IDXW : tcs_pkg::SLOT_W;
  localparam int FW   = tcs_pkg::FRAC_W;
  localparam int SW   = tcs_pkg::SECS_W;

  logic [FW-1:0]        step_frac;
  logic [SW-1:0]        clk_secs;
  logic [FW-1:0]        clk_frac;
  tcs_pkg::slot_t       in_slot;
  logic [CNTW-1:0]      cnt;
  logic [IDXW-1:0]      cnt_idx;
  logic [NUM_SLOTS-1:0] used;
  tcs_pkg::slot_t       mem [NUM_SLOTS];
  tcs_pkg::slot_t       rd_data;
  logic [IDXW-1:0]      rd_idx;
  logic                 rd_vld;
  logic                 pend_vld;
  logic [IDXW-1:0]      pend_idx;
  logic [tcs_pkg::TAG_W-1:0] pend_tag;

  logic                 due, one_shot, hit;
  logic [SW-1:0]        base_secs;
  logic [FW:0]          due_fsum;
  logic [FW:0]          clk_fsum;
  tcs_pkg::slot_t       upd;
  logic                 mem_we;
  logic [IDXW-1:0]      mem_waddr;
  tcs_pkg::slot_t       mem_wdata;
  logic [XW-1:0]        pend_x, cnt_x;

  logic                              done_next, fired_next, accepted_next, last_next;
  logic [tcs_pkg::SLOT_W-1:0]        slot_next;
  logic [tcs_pkg::TAG_W-1:0]         tag_next;

  assign cnt_idx        = cnt[IDXW-1:0];
  assign stat.cnt_end   = (cnt == CNTW'(NUM_SLOTS));
  assign stat.slot_free = !used[cnt_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_frac <= FW'(1);
    end else if (cfg_we) begin
      step_frac <= cfg_wdata;
    end
  end

  // Clock advance: both terms below 1024, so the carry out of one add is the seconds increment.
  assign clk_fsum = {1'b0, clk_frac} + {1'b0, step_frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_secs <= '0;
      clk_frac <= '0;
    end else if (cmd.clk_adv) begin
      clk_frac <= clk_fsum[FW-1:0];
      clk_secs <= clk_secs + SW'(clk_fsum[FW]);
    end else if (cmd.clk_load) begin
      clk_secs <= in_slot.due_secs;
      clk_frac <= in_slot.due_frac;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      in_slot.due_secs <= time_secs;
      in_slot.due_frac <= time_frac;
      in_slot.rep_secs <= period_secs;
      in_slot.rep_frac <= repeat_frac;
      in_slot.tag      <= event_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cap) begin
      cnt <= '0;
    end else if (cmd.scan_step || cmd.find_step) begin
      cnt <= cnt + CNTW'(1);
    end
  end

  // Evaluate the slot read in the previous cycle.
  assign due       = (rd_data.due_secs < clk_secs) ||
                     ((rd_data.due_secs == clk_secs) && (rd_data.due_frac <= clk_frac));
  assign one_shot  = (rd_data.rep_secs == '0) && (rd_data.rep_frac == '0);
  assign hit       = rd_vld && due;
  assign base_secs = ((rd_data.due_secs == '0) && (rd_data.due_frac == '0)) ?
                     clk_secs : rd_data.due_secs;
  assign due_fsum  = {1'b0, rd_data.due_frac} + {1'b0, rd_data.rep_frac};

  always_comb begin
    upd          = rd_data;
    upd.due_frac = due_fsum[FW-1:0];
    upd.due_secs = base_secs + rd_data.rep_secs + SW'(due_fsum[FW]);
  end

  assign mem_we    = cmd.place || (hit && !one_shot);
  assign mem_waddr = cmd.place ? cnt_idx : rd_idx;
  assign mem_wdata = cmd.place ? in_slot : upd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.scan_step) begin
      rd_data <= mem[cnt_idx];
    end
    rd_idx <= cnt_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_step && used[cnt_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (cmd.place) used[cnt_idx] <= 1'b1;
      if (hit && one_shot) used[rd_idx] <= 1'b0;
    end
  end

  // One fired result is held back until the scan shows whether it is the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
    end else if (cmd.cap) begin
      pend_vld <= 1'b0;
    end else if (hit) begin
      pend_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      pend_idx <= rd_idx;
      pend_tag <= rd_data.tag;
    end
  end

  assign pend_x = XW'(pend_idx);
  assign cnt_x  = XW'(cnt_idx);

  always_comb begin
    done_next     = 1'b0;
    fired_next    = 1'b0;
    slot_next     = '0;
    tag_next      = '0;
    accepted_next = 1'b0;
    last_next     = 1'b0;
    if (hit && pend_vld) begin
      done_next  = 1'b1;
      fired_next = 1'b1;
      slot_next  = pend_x[tcs_pkg::SLOT_W-1:0];
      tag_next   = pend_tag;
    end else if (cmd.drain) begin
      done_next  = 1'b1;
      last_next  = 1'b1;
      fired_next = pend_vld;
      if (pend_vld) begin
        slot_next = pend_x[tcs_pkg::SLOT_W-1:0];
        tag_next  = pend_tag;
      end
    end else if (cmd.place) begin
      done_next     = 1'b1;
      last_next     = 1'b1;
      accepted_next = 1'b1;
      slot_next     = cnt_x[tcs_pkg::SLOT_W-1:0];
    end else if (cmd.full || cmd.plain) begin
      done_next = 1'b1;
      last_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    fired      <= fired_next;
    slot_index <= slot_next;
    tag_out    <= tag_next;
    accepted   <= accepted_next;
    last       <= last_next;
    now_secs   <= clk_secs;
    now_frac   <= clk_frac;
  end

endmodule
`default_nettype wire

// ===== sv/tick_clock_event_scheduler_core.sv =====
// Top level of the tick clock event scheduler: sequencer plus datapath.
// Tick: steps the clock, then reads one slot per cycle, then gives the final
//   result; a fired result is held until the next due slot or the end of the scan.
// Schedule: searches from slot 0 for the first free slot and places the event there, or reports full.
// Set time: loads the clock, then gives a plain result; unused opcode: plain result only.
// Synchronous active-high reset: clock 0, all slots free, step 1 fraction/tick.
// Results are one-cycle strobes on done; the receiver cannot stall them.
`default_nettype none
module tick_clock_event_scheduler_core #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration: fraction units added per tick
  input  wire logic                       cfg_we,
  input  wire logic [tcs_pkg::FRAC_W-1:0] cfg_wdata,
  // item in: taken when start && !busy
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [tcs_pkg::OP_W-1:0]   opcode,
  input  wire logic [tcs_pkg::SECS_W-1:0] time_secs,
  input  wire logic [tcs_pkg::FRAC_W-1:0] time_frac,
  input  wire logic [tcs_pkg::SECS_W-1:0] period_secs,
  input  wire logic [tcs_pkg::FRAC_W-1:0] repeat_frac,
  input  wire logic [tcs_pkg::TAG_W-1:0]  event_tag,
  // results out: one per done strobe
  output logic                            done,
  output logic                            fired,
  output logic [tcs_pkg::SLOT_W-1:0]      slot_index,
  output logic [tcs_pkg::TAG_W-1:0]       tag_out,
  output logic                            accepted,
  output logic [tcs_pkg::SECS_W-1:0]      now_secs,
  output logic [tcs_pkg::FRAC_W-1:0]      now_frac,
  output logic                            last
);

  tcs_pkg::cmd_t  cmd;
  tcs_pkg::stat_t stat;

  // Sequencer: decodes the op on accept, then walks the slot counter for ticks and schedules.
  tcs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath: slot table is a single-port-write memory with registered read;
  // in-use bits live in flops so reset frees every slot at once.
  tcs_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .time_secs   (time_secs),
    .time_frac   (time_frac),
    .period_secs (period_secs),
    .repeat_frac (repeat_frac),
    .event_tag   (event_tag),
    .done        (done),
    .fired       (fired),
    .slot_index  (slot_index),
    .tag_out     (tag_out),
    .accepted    (accepted),
    .now_secs    (now_secs),
    .now_frac    (now_frac),
    .last        (last)
  );

endmodule
`default_nettype wire

// ===== sv/tcs_chk.sv =====
// Port-level checks for the scheduler, bound to the top level.
`default_nettype none
module tcs_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic fired,
  input wire logic accepted,
  input wire logic last
);

  // an accepted item makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy next cycle");

  // a placed schedule request is a single, non-fired result
  a_place_shape: assert property (@(posedge clk) disable iff (rst)
    (done && accepted) |-> (!fired && last))
    else $error("schedule result malformed");

  // only fired events can be followed by more results of the same item
  a_nonlast_fired: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |-> fired)
    else $error("non-final result without a fired event");

  // once idle again, the item's final result is the one showing
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (done && !busy) |-> last)
    else $error("block idle while item results still pending");

endmodule

bind tick_clock_event_scheduler_core tcs_chk u_tcs_chk (.*);
`default_nettype wire
